// ===== rtl/core/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants of the process scheduler
// Slot count, field widths, command and place codes.
// ----------------------------------------------------------------------------
package cps_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotBits = $clog2(Slots);
  localparam int unsigned CntBits = $clog2(Slots + 1);
  localparam int unsigned IdBits = 8;
  localparam int unsigned RtBits = 16;
  localparam int unsigned PrBits = 8;

  typedef enum logic [2:0] {
    CMD_STEP  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_BLOCK = 3'd2,
    CMD_WAKE  = 3'd3,
    CMD_PEEK  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_SJF  = 2'd1,
    MODE_RR   = 2'd2,
    MODE_PP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PLACE_FREE   = 2'd0,
    PLACE_NEW    = 2'd1,
    PLACE_ACTIVE = 2'd2,
    PLACE_WAIT   = 2'd3
  } place_e;

  // One ready queue entry: a slot index with its sort keys.
  typedef struct packed {
    logic [SlotBits-1:0] slot;
    logic [RtBits-1:0]   left;
    logic [PrBits-1:0]   urg;
  } entry_t;

  // Queue operation broadcast to every cell.
  typedef struct packed {
    logic   ins;    // sorted or appended insertion
    logic   sorted; // insert by key, else append
    logic   sjf;    // key is remaining runtime, else priority
    logic   pop;    // remove the head
    entry_t ent;
  } qop_t;
endpackage

// ===== rtl/core/cps_cell.sv =====
// ----------------------------------------------------------------------------
// cps_cell: one place of the ready queue
// Holds one entry and shifts with its neighbors on insert and pop.
// ----------------------------------------------------------------------------
module cps_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cps_pkg::qop_t  op_i,
  input  logic           prev_valid_i,
  input  logic           prev_ahead_i,
  input  cps_pkg::entry_t prev_ent_i,
  input  logic           next_valid_i,
  input  cps_pkg::entry_t next_ent_i,
  output logic           valid_o,
  output logic           ahead_o,
  output cps_pkg::entry_t ent_o
);
  import cps_pkg::*;

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;
  logic   stay;

  // This entry stays ahead of the incoming one.
  always_comb begin
    if (!op_i.sorted) stay = 1'b1;
    else if (op_i.sjf) stay = ent_q.left <= op_i.ent.left;
    else stay = ent_q.urg >= op_i.ent.urg;
  end
  // Only an unbroken run of entries from the head stays ahead, so the
  // insertion point is the first entry that does not.
  assign ahead_o = valid_q && stay && prev_ahead_i;
  assign valid_o = valid_q;
  assign ent_o   = ent_q;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (op_i.pop) begin
      valid_d = next_valid_i;
      ent_d   = next_ent_i;
    end else if (op_i.ins && !ahead_o && prev_ahead_i) begin
      valid_d = 1'b1;
      ent_d   = op_i.ent;
    end else if (op_i.ins && !ahead_o) begin
      valid_d = prev_valid_i;
      ent_d   = prev_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end
endmodule

// ===== rtl/core/cpu_process_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// cpu_process_scheduler_core: FCFS, SJF, round robin and priority scheduler
// Slot table with a ready queue held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Steps: an item goes from accept to result through decode, a wake insert,
// the admission of each new process into the cell row (one insert per
// cycle), the run step, a possible requeue and dispatch. A show or an add
// without advance goes from decode straight to the result.
// Throughput: one item at a time; the next is accepted once the result is taken.
// Reset: asynchronous active low; all slots free, queue empty, nothing runs.
module cpu_process_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], proc_id[10:3], runtime[26:11], priority_req[34:27], advance[35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // running_valid[0], running_id[8:1], running_left[24:9], ready_count[29:25],
  // table_full[30], not_found[31]
  output logic [31:0] m_axis_tdata
);
  import cps_pkg::*;

  localparam logic [0:0] RegMode = 1'd0;
  localparam logic [0:0] RegQuantum = 1'd1;

  // ST_RUN decodes the latched command; ST_WAKE inserts a woken process.
  typedef enum logic [2:0] {
    ST_IDLE, ST_ADMIT, ST_RUN, ST_REQ, ST_DISP, ST_OUT, ST_WAKE
  } state_e;

  state_e state_q;
  logic [1:0] mode_q;
  logic [7:0] quantum_q;

  // Slot table; ident, left and urgency are payload without reset.
  logic [IdBits-1:0] ident_q [Slots];
  logic [RtBits-1:0] left_q [Slots];
  logic [PrBits-1:0] urg_q [Slots];
  place_e place_q [Slots];

  // Arrival list as a small FIFO of slot indexes.
  logic [SlotBits-1:0] arr_q [Slots];
  logic [CntBits-1:0] arr_len_q, arr_rd_q;

  logic [CntBits-1:0] rlen_q;
  logic run_v_q;
  logic [SlotBits-1:0] run_s_q;
  logic [7:0] slice_q;
  logic full_q, miss_q;

  // Latched input item.
  logic [2:0] cmd_q;
  logic [IdBits-1:0] id_q;
  logic [RtBits-1:0] rt_q;
  logic [PrBits-1:0] pr_q;
  logic adv_q;

  // Cell row.
  qop_t op;
  logic [Slots:0] cv;
  logic [Slots:0] ca;
  entry_t ce [Slots+1];

  assign cv[0] = 1'b0;
  assign ca[0] = 1'b1;
  assign ce[0] = op.ent;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    logic nv;
    entry_t ne;
    if (g == Slots - 1) begin : g_end
      assign nv = 1'b0;
      assign ne = ce[g+1];
    end else begin : g_mid
      assign nv = cv[g+2];
      assign ne = ce[g+2];
    end
    cps_cell u_cell (
      .clk_i, .rst_ni, .op_i(op),
      .prev_valid_i(cv[g]), .prev_ahead_i(ca[g]), .prev_ent_i(ce[g]),
      .next_valid_i(nv), .next_ent_i(ne),
      .valid_o(cv[g+1]), .ahead_o(ca[g+1]), .ent_o(ce[g+1])
    );
  end

  // Free slot and waiting match searches, lowest index first.
  logic free_f, wait_f;
  logic [SlotBits-1:0] free_s, wait_s;
  always_comb begin
    free_f = 1'b0; free_s = '0; wait_f = 1'b0; wait_s = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (place_q[i] == PLACE_FREE) begin
        free_f = 1'b1; free_s = SlotBits'(i);
      end
      if (place_q[i] == PLACE_WAIT && ident_q[i] == id_q) begin
        wait_f = 1'b1; wait_s = SlotBits'(i);
      end
    end
  end

  // The woken slot is marked active at decode, so the search no longer finds
  // it; its index is held here for the insert in the following cycle.
  logic [SlotBits-1:0] wake_s_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) wake_s_q <= wait_s;
  end

  logic preempt;
  logic [SlotBits-1:0] ins_s;
  logic [SlotBits-1:0] arr_s;
  logic [7:0] slice_inc;
  assign preempt = mode_q == MODE_RR || mode_q == MODE_PP;
  assign arr_s = arr_q[arr_rd_q[SlotBits-1:0]];
  assign slice_inc = (slice_q == 8'hFF) ? slice_q : slice_q + 8'd1;

  always_comb begin
    op = '0;
    op.sorted = mode_q == MODE_SJF || mode_q == MODE_PP;
    op.sjf = mode_q == MODE_SJF;
    ins_s = run_s_q;
    if (state_q == ST_ADMIT && arr_rd_q != arr_len_q) begin
      ins_s = arr_s;
      op.ins = 1'b1;
    end else if (state_q == ST_WAKE) begin
      ins_s = wake_s_q;
      op.ins = 1'b1;
    end else if (state_q == ST_REQ) begin
      op.ins = 1'b1;
    end
    if (state_q == ST_DISP) op.pop = !run_v_q && rlen_q != '0;
    op.ent.slot = ins_s;
    op.ent.left = left_q[ins_s];
    op.ent.urg  = urg_q[ins_s];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= 2'd0;
      quantum_q <= 8'd0;
      for (int i = 0; i < Slots; i++) place_q[i] <= PLACE_FREE;
      arr_len_q <= '0;
      arr_rd_q <= '0;
      rlen_q <= '0;
      run_v_q <= 1'b0;
      run_s_q <= '0;
      slice_q <= 8'd0;
      full_q <= 1'b0;
      miss_q <= 1'b0;
      cmd_q <= CMD_PEEK;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegMode) mode_q <= cfg_data_i[1:0];
      if (cfg_we_i && cfg_idx_i == RegQuantum) quantum_q <= cfg_data_i;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q <= s_axis_tdata[2:0];
            id_q  <= s_axis_tdata[10:3];
            rt_q  <= s_axis_tdata[26:11];
            pr_q  <= s_axis_tdata[34:27];
            adv_q <= s_axis_tdata[35];
            full_q <= 1'b0;
            miss_q <= 1'b0;
            state_q <= ST_RUN; // decode step
            arr_rd_q <= '0;
          end
        end
        ST_RUN: begin
          unique case (cmd_q)
            CMD_STEP: state_q <= ST_ADMIT;
            CMD_ADD: begin
              if (free_f && arr_len_q != CntBits'(Slots)) begin
                ident_q[free_s] <= id_q;
                left_q[free_s] <= rt_q;
                urg_q[free_s] <= pr_q;
                place_q[free_s] <= PLACE_NEW;
                arr_q[arr_len_q[SlotBits-1:0]] <= free_s;
                arr_len_q <= arr_len_q + CntBits'(1);
              end else full_q <= 1'b1;
              state_q <= adv_q ? ST_ADMIT : ST_OUT;
            end
            CMD_BLOCK: begin
              slice_q <= 8'd0;
              if (run_v_q) place_q[run_s_q] <= PLACE_WAIT;
              run_v_q <= 1'b0;
              state_q <= ST_ADMIT;
            end
            CMD_WAKE: begin
              if (wait_f) begin
                place_q[wait_s] <= PLACE_ACTIVE;
                state_q <= ST_WAKE;
              end else begin
                miss_q <= 1'b1;
                state_q <= ST_ADMIT;
              end
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_WAKE: begin
          // The cell row places the woken process by the mode's rule.
          rlen_q <= rlen_q + CntBits'(1);
          state_q <= ST_ADMIT;
        end
        ST_ADMIT: begin
          if (op.ins) begin
            place_q[arr_s] <= PLACE_ACTIVE;
            arr_rd_q <= arr_rd_q + CntBits'(1);
            rlen_q <= rlen_q + CntBits'(1);
          end else begin
            arr_len_q <= '0;
            arr_rd_q <= '0;
            // run step
            if (run_v_q) begin
              if (left_q[run_s_q] <= RtBits'(1)) begin
                left_q[run_s_q] <= '0;
                place_q[run_s_q] <= PLACE_FREE;
                run_v_q <= 1'b0;
                slice_q <= 8'd0;
                state_q <= ST_DISP;
              end else begin
                left_q[run_s_q] <= left_q[run_s_q] - RtBits'(1);
                if (preempt && slice_inc >= quantum_q) begin
                  slice_q <= 8'd0;
                  run_v_q <= 1'b0;
                  state_q <= ST_REQ;
                end else begin
                  slice_q <= slice_inc;
                  state_q <= ST_DISP;
                end
              end
            end else state_q <= ST_DISP;
          end
        end
        ST_REQ: begin
          rlen_q <= rlen_q + CntBits'(1);
          state_q <= ST_DISP;
        end
        ST_DISP: begin
          if (op.pop) begin
            run_v_q <= 1'b1;
            run_s_q <= ce[1].slot;
            rlen_q <= rlen_q - CntBits'(1);
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = state_q == ST_OUT;
  assign m_axis_tdata = {miss_q, full_q, rlen_q, run_v_q ? left_q[run_s_q] : 16'd0,
                         run_v_q ? ident_q[run_s_q] : 8'd0, run_v_q};

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rlen_q <= CntBits'(Slots)) else $error("ready queue overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule
